>>> rtl/core/array_double_ended_queue_defines.svh
// ----------------------------------------------------------------------------
// array double-ended queue assertion macros
// shared assertion shorthands for the queue rtl
// ----------------------------------------------------------------------------
`ifndef ARRAY_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define ARRAY_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// property checked on every clock edge outside reset
`define ADEQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression that must never be true outside reset
`define ADEQ_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

>>> rtl/core/adeq_pkg.sv
// ----------------------------------------------------------------------------
// adeq_pkg
// types, codes and microcode program of the array double-ended queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adeq_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // microcode addresses
  typedef enum logic [3:0] {
    UPC_FETCH       = 4'd0,
    UPC_FULL        = 4'd1,
    UPC_EMPTY       = 4'd2,
    UPC_PUSH_INIT   = 4'd3,
    UPC_PUSH_BACK   = 4'd4,
    UPC_PUSH_FRONT  = 4'd5,
    UPC_SHIFT_PRIME = 4'd6,
    UPC_SHIFT_LOOP  = 4'd7,
    UPC_SHIFT_PUT   = 4'd8,
    UPC_POPF_RD     = 4'd9,
    UPC_POPF_FIN    = 4'd10,
    UPC_POPB_RD     = 4'd11,
    UPC_POPB_FIN    = 4'd12
  } upc_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_FRONT,
    RD_BACK,
    RD_PTR_M2
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ZERO,
    WR_BACK_P1,
    WR_FRONT_M1,
    WR_PTR
  } wr_sel_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_INIT,
    IDX_BACK_INC,
    IDX_FRONT_DEC,
    IDX_POP_FRONT,
    IDX_POP_BACK,
    IDX_PTR_LOAD,
    IDX_PTR_DEC
  } idx_op_e;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_DONE,
    RES_FULL,
    RES_EMPTY,
    RES_POP
  } res_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_FETCH,
    JMP_DISPATCH,
    JMP_LOOP
  } jmp_e;

  typedef struct packed {
    logic    ld_val;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    idx_op_e idx_op;
    res_e    res;
    jmp_e    jmp;
    upc_e    target;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic front_zero;
    logic ptr_last;
  } stat_t;

  // control store
  function automatic ctrl_t ucode_rom(upc_e addr);
    ctrl_t w;
    w.ld_val = 1'b0;
    w.rd_sel = RD_NONE;
    w.wr_sel = WR_NONE;
    w.idx_op = IDX_HOLD;
    w.res    = RES_NONE;
    w.jmp    = JMP_FETCH;
    w.target = UPC_FETCH;
    case (addr)
      UPC_FETCH: begin
        w.ld_val = 1'b1;
        w.jmp    = JMP_DISPATCH;
      end
      UPC_FULL: begin
        w.res = RES_FULL;
      end
      UPC_EMPTY: begin
        w.res = RES_EMPTY;
      end
      UPC_PUSH_INIT: begin
        w.wr_sel = WR_ZERO;
        w.idx_op = IDX_INIT;
        w.res    = RES_DONE;
      end
      UPC_PUSH_BACK: begin
        w.wr_sel = WR_BACK_P1;
        w.idx_op = IDX_BACK_INC;
        w.res    = RES_DONE;
      end
      UPC_PUSH_FRONT: begin
        w.wr_sel = WR_FRONT_M1;
        w.idx_op = IDX_FRONT_DEC;
        w.res    = RES_DONE;
      end
      UPC_SHIFT_PRIME: begin
        w.rd_sel = RD_BACK;
        w.idx_op = IDX_PTR_LOAD;
        w.jmp    = JMP_NEXT;
      end
      UPC_SHIFT_LOOP: begin
        w.rd_sel = RD_PTR_M2;
        w.wr_sel = WR_PTR;
        w.idx_op = IDX_PTR_DEC;
        w.jmp    = JMP_LOOP;
        w.target = UPC_SHIFT_LOOP;
      end
      UPC_SHIFT_PUT: begin
        w.wr_sel = WR_ZERO;
        w.idx_op = IDX_BACK_INC;
        w.res    = RES_DONE;
      end
      UPC_POPF_RD: begin
        w.rd_sel = RD_FRONT;
        w.jmp    = JMP_NEXT;
      end
      UPC_POPF_FIN: begin
        w.idx_op = IDX_POP_FRONT;
        w.res    = RES_POP;
      end
      UPC_POPB_RD: begin
        w.rd_sel = RD_BACK;
        w.jmp    = JMP_NEXT;
      end
      UPC_POPB_FIN: begin
        w.idx_op = IDX_POP_BACK;
        w.res    = RES_POP;
      end
      default: begin
        w.jmp = JMP_FETCH;
      end
    endcase
    return w;
  endfunction

  // entry point of each request
  function automatic upc_e dispatch(logic [1:0] op, stat_t st);
    upc_e t;
    if (op inside {OP_PUSH_BACK, OP_PUSH_FRONT}) begin
      if (st.full) begin
        t = UPC_FULL;
      end else if (st.empty) begin
        t = UPC_PUSH_INIT;
      end else if (op == OP_PUSH_BACK) begin
        t = UPC_PUSH_BACK;
      end else if (st.front_zero) begin
        t = UPC_SHIFT_PRIME;
      end else begin
        t = UPC_PUSH_FRONT;
      end
    end else if (st.empty) begin
      t = UPC_EMPTY;
    end else if (op == OP_POP_FRONT) begin
      t = UPC_POPF_RD;
    end else begin
      t = UPC_POPB_RD;
    end
    return t;
  endfunction

endpackage

>>> rtl/core/adeq_seq.sv
// ----------------------------------------------------------------------------
// adeq_seq
// step counter, control store and jump logic of the queue sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adeq_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     op_i,
  input  logic           out_busy_i,
  input  adeq_pkg::stat_t stat_i,
  output logic           in_ready_o,
  output adeq_pkg::ctrl_t ctrl_o
);
  import adeq_pkg::*;

  upc_e  upc_q, upc_d;
  ctrl_t word;
  logic  go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

  always_comb begin
    word       = ucode_rom(upc_q);
    in_ready_o = (upc_q == UPC_FETCH);
    // a result step waits while the output register is still held
    go         = !((word.res != RES_NONE) && out_busy_i);

    ctrl_o        = word;
    ctrl_o.ld_val = word.ld_val & in_valid_i;
    if ((word.rd_sel == RD_PTR_M2) && stat_i.ptr_last) begin
      ctrl_o.rd_sel = RD_NONE;
    end
    if (!go) begin
      ctrl_o.rd_sel = RD_NONE;
      ctrl_o.wr_sel = WR_NONE;
      ctrl_o.idx_op = IDX_HOLD;
      ctrl_o.res    = RES_NONE;
    end

    upc_d = upc_q;
    if (go) begin
      case (word.jmp)
        JMP_NEXT:     upc_d = upc_e'(upc_q + 4'd1);
        JMP_FETCH:    upc_d = UPC_FETCH;
        JMP_DISPATCH: upc_d = in_valid_i ? dispatch(op_i, stat_i) : upc_q;
        JMP_LOOP:     upc_d = stat_i.ptr_last ? upc_e'(upc_q + 4'd1) : word.target;
        default:      upc_d = UPC_FETCH;
      endcase
    end
  end

endmodule

>>> rtl/core/adeq_dpath.sv
// ----------------------------------------------------------------------------
// adeq_dpath
// storage array, front and back indices, shift pointer and read register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adeq_dpath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  adeq_pkg::ctrl_t        ctrl_i,
  input  logic signed [31:0]     push_value_i,
  output adeq_pkg::stat_t        stat_o,
  output logic signed [31:0]     rd_data_o,
  output logic                   empty_next_o
);
  import adeq_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
  localparam logic [IW-1:0] ONE  = IW'(1);
  localparam logic [IW-1:0] TWO  = IW'(2);

  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic signed [DATA_W-1:0] val_q, rd_q, wr_data;
  logic [IW-1:0]            front_q, front_d, back_q, back_d, ptr_q, ptr_d;
  logic [IW-1:0]            wr_addr, rd_addr;
  logic                     empty_q, empty_d, wr_en, rd_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      ptr_q   <= '0;
      empty_q <= 1'b1;
    end else begin
      front_q <= front_d;
      back_q  <= back_d;
      ptr_q   <= ptr_d;
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_val) begin
      val_q <= push_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_data = val_q;
    case (ctrl_i.wr_sel)
      WR_ZERO:     wr_addr = '0;
      WR_BACK_P1:  wr_addr = back_q + ONE;
      WR_FRONT_M1: wr_addr = front_q - ONE;
      WR_PTR: begin
        wr_addr = ptr_q;
        wr_data = rd_q;
      end
      default: begin
        wr_en   = 1'b0;
        wr_addr = '0;
      end
    endcase

    rd_en = 1'b1;
    case (ctrl_i.rd_sel)
      RD_FRONT:  rd_addr = front_q;
      RD_BACK:   rd_addr = back_q;
      RD_PTR_M2: rd_addr = ptr_q - TWO;
      default: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
    endcase

    front_d = front_q;
    back_d  = back_q;
    ptr_d   = ptr_q;
    empty_d = empty_q;
    case (ctrl_i.idx_op)
      IDX_INIT: begin
        front_d = '0;
        back_d  = '0;
        empty_d = 1'b0;
      end
      IDX_BACK_INC:  back_d  = back_q + ONE;
      IDX_FRONT_DEC: front_d = front_q - ONE;
      IDX_POP_FRONT, IDX_POP_BACK: begin
        if (front_q == back_q) begin
          front_d = '0;
          back_d  = '0;
          empty_d = 1'b1;
        end else if (ctrl_i.idx_op == IDX_POP_FRONT) begin
          front_d = front_q + ONE;
        end else begin
          back_d = back_q - ONE;
        end
      end
      IDX_PTR_LOAD: ptr_d = back_q + ONE;
      IDX_PTR_DEC:  ptr_d = ptr_q - ONE;
      default: ;
    endcase
  end

  assign stat_o.empty      = empty_q;
  assign stat_o.full       = !empty_q && (back_q == LAST);
  assign stat_o.front_zero = (front_q == '0);
  assign stat_o.ptr_last   = (ptr_q == ONE);
  assign rd_data_o         = rd_q;
  assign empty_next_o      = empty_d;

endmodule

>>> rtl/core/array_double_ended_queue.sv
// ----------------------------------------------------------------------------
// array_double_ended_queue: deque over a linear array, microcoded control
// steps: fetch, then a result step for a push, refused push or refused pop;
//   read and finish for a pop; prime, shift loop and put for a push front at 0
// requests are taken only in fetch; a result step waits while the result is held
// reset: indices cleared and queue empty; storage is not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "array_double_ended_queue_defines.svh"

module array_double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] push_value_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pop_value_o,
  output logic [1:0]         status_o,
  output logic               empty_after_o
);
  import adeq_pkg::*;

  // sequencer to datapath control word and status flags back
  ctrl_t              ctrl;
  stat_t              stat;
  logic signed [31:0] rd_data;
  logic               empty_next;

  // result register, parts the result channel from the sequencer
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] pop_value_q, pop_value_d;
  logic [1:0]         status_q, status_d;
  logic               empty_after_q, empty_after_d;
  logic               out_busy;

  // a held result only blocks a new one if it is not taken this cycle
  assign out_busy = out_valid_q && !out_ready_i;

  adeq_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .out_busy_i (out_busy),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  adeq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .push_value_i (push_value_i),
    .stat_o       (stat),
    .rd_data_o    (rd_data),
    .empty_next_o (empty_next)
  );

  // result formatting: pop data only on a successful pop, empty flag after update
  always_comb begin
    out_valid_d   = out_valid_q && !out_ready_i;
    pop_value_d   = pop_value_q;
    status_d      = status_q;
    empty_after_d = empty_after_q;
    if (ctrl.res != RES_NONE) begin
      out_valid_d   = 1'b1;
      pop_value_d   = (ctrl.res == RES_POP) ? rd_data : '0;
      empty_after_d = empty_next;
      case (ctrl.res)
        RES_FULL:  status_d = ST_FULL;
        RES_EMPTY: status_d = ST_EMPTY;
        default:   status_d = ST_DONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pop_value_q   <= pop_value_d;
    status_q      <= status_d;
    empty_after_q <= empty_after_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pop_value_o   = pop_value_q;
  assign status_o      = status_q;
  assign empty_after_o = empty_after_q;

  // an accepted request always leaves the fetch step
  `ADEQ_ASSERT(a_accept_leaves_fetch, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "request accepted but sequencer stayed in fetch")
  // refused requests never carry data (pushes are not checked here)
  `ADEQ_ASSERT(a_refused_no_data, clk_i, rst_ni, out_valid_o && (status_o != ST_DONE) |-> pop_value_o == '0, "refused request carries data")
  // a pop refused for empty leaves the queue empty
  `ADEQ_ASSERT(a_empty_refusal, clk_i, rst_ni, out_valid_o && (status_o == ST_EMPTY) |-> empty_after_o, "empty refusal with non-empty queue")
  // a result is never produced while the result register is held
  `ADEQ_ASSERT_NEVER(a_no_overrun, clk_i, rst_ni, out_busy && (ctrl.res != RES_NONE), "result overwrites a held result")

endmodule

>>> tb/tb_array_double_ended_queue.sv
// ----------------------------------------------------------------------------
// tb_array_double_ended_queue
// self-checking bench for the array deque: a clocked driver feeds requests
// from a queue, a clocked monitor compares every result against a software
// copy of the deque that is updated as each request is accepted
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_array_double_ended_queue;
  import adeq_pkg::*;

  localparam int unsigned DEPTH = 16;

  typedef struct {
    op_e                op;
    logic signed [31:0] value;
  } request_t;

  typedef struct {
    logic signed [31:0] pop_value;
    status_e            status;
    logic               empty_after;
  } outcome_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [1:0]         op_i          = OP_PUSH_BACK;
  logic signed [31:0] push_value_i  = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic signed [31:0] pop_value_o;
  logic [1:0]         status_o;
  logic               empty_after_o;

  array_double_ended_queue #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pop_value_o  (pop_value_o),
    .status_o     (status_o),
    .empty_after_o(empty_after_o)
  );

  // software copy of the deque
  logic signed [31:0] deq_mem [DEPTH];
  int                 deq_front;
  int                 deq_back;
  bit                 deq_empty;

  request_t    request_q[$];
  outcome_t    outcome_q[$];
  int          total_req;
  int          accepted_cnt;
  int          seen_cnt;
  int          mismatch_cnt;
  int unsigned send_gap;
  int unsigned rx_gap;
  bit          send_busy;
  bit          rx_rdy;
  bit          rx_hold;
  bit          hold_used;
  int unsigned hold_left;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // apply one request to the software deque and queue its outcome
  function automatic void deque_apply(op_e op, logic signed [31:0] val);
    outcome_t o;
    int       i;
    o.pop_value = '0;
    o.status    = ST_DONE;
    if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) begin
      // refused once the back hits the last slot, free front slots or not
      if (!deq_empty && deq_back >= DEPTH - 1) begin
        o.status = ST_FULL;
      end else if (deq_empty) begin
        deq_front  = 0;
        deq_back   = 0;
        deq_empty  = 1'b0;
        deq_mem[0] = val;
      end else if (op == OP_PUSH_BACK) begin
        deq_back          = deq_back + 1;
        deq_mem[deq_back] = val;
      end else if (deq_front == 0) begin
        // no room in front: move everything up one slot
        for (i = deq_back + 1; i > 0; i--) begin
          deq_mem[i] = deq_mem[i-1];
        end
        deq_back   = deq_back + 1;
        deq_mem[0] = val;
      end else begin
        deq_front          = deq_front - 1;
        deq_mem[deq_front] = val;
      end
    end else if (deq_empty) begin
      o.status = ST_EMPTY;
    end else begin
      o.pop_value = (op == OP_POP_FRONT) ? deq_mem[deq_front] : deq_mem[deq_back];
      if (deq_front == deq_back) begin
        deq_front = 0;
        deq_back  = 0;
        deq_empty = 1'b1;
      end else if (op == OP_POP_FRONT) begin
        deq_front = deq_front + 1;
      end else begin
        deq_back = deq_back - 1;
      end
    end
    o.empty_after = deq_empty;
    outcome_q.push_back(o);
  endfunction

  // mostly short gaps, a few long ones, none at all in calm stretches
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // mode 0 leans to pushes, mode 1 to pops, mode 2 is uniform
  function automatic op_e pick_op(int mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (mode == 0) begin
      if (r < 45) return OP_PUSH_BACK;
      if (r < 75) return OP_PUSH_FRONT;
      if (r < 88) return OP_POP_FRONT;
      return OP_POP_BACK;
    end else if (mode == 1) begin
      if (r < 12) return OP_PUSH_BACK;
      if (r < 25) return OP_PUSH_FRONT;
      if (r < 62) return OP_POP_FRONT;
      return OP_POP_BACK;
    end
    return op_e'($urandom_range(0, 3));
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_request(op_e op, logic signed [31:0] val);
    request_t r;
    r.op    = op;
    r.value = val;
    request_q.push_back(r);
    total_req++;
  endtask

  // driver: present the next request after a random gap, predict on accept
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      op_i         <= OP_PUSH_BACK;
      push_value_i <= '0;
      send_gap      = 0;
    end else begin
      send_busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        deque_apply(op_e'(op_i), push_value_i);
        accepted_cnt <= accepted_cnt + 1;
        send_busy     = 1'b0;
        send_gap      = pick_gap((accepted_cnt / 60) % 4 == 1);
      end
      if (!send_busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_q.size() > 0) begin
          op_i         <= request_q[0].op;
          push_value_i <= request_q[0].value;
          void'(request_q.pop_front());
          send_busy = 1'b1;
        end
      end
      in_valid_i <= send_busy;
    end
  end

  // one long receiver hold-off once the run is well under way, so the
  // result stays parked and the block has to stall its request side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_hold   <= 1'b0;
      hold_used <= 1'b0;
      hold_left <= 0;
    end else if (rx_hold) begin
      if (hold_left == 0) begin
        rx_hold <= 1'b0;
      end else begin
        hold_left <= hold_left - 1;
      end
    end else if (!hold_used && accepted_cnt >= 300) begin
      rx_hold   <= 1'b1;
      hold_used <= 1'b1;
      hold_left <= 400;
    end
  end

  // monitor: compare each accepted result with the oldest outcome
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_gap       = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (outcome_q.size() == 0) begin
          $error("result with no request outstanding: pop_value %0d status %0d",
                 pop_value_o, status_o);
          mismatch_cnt++;
        end else begin
          if (pop_value_o !== outcome_q[0].pop_value) begin
            $error("pop_value: expected %0d, got %0d", outcome_q[0].pop_value, pop_value_o);
            mismatch_cnt++;
          end
          if (status_o !== outcome_q[0].status) begin
            $error("status: expected %0d, got %0d", outcome_q[0].status, status_o);
            mismatch_cnt++;
          end
          if (empty_after_o !== outcome_q[0].empty_after) begin
            $error("empty_after: expected %0d, got %0d", outcome_q[0].empty_after,
                   empty_after_o);
            mismatch_cnt++;
          end
          void'(outcome_q.pop_front());
        end
        seen_cnt <= seen_cnt + 1;
        rx_gap    = pick_gap((seen_cnt / 60) % 4 inside {1, 2});
      end else if (rx_gap == 0 && $urandom_range(0, 7) == 0) begin
        // occasional stall while the block is still working
        rx_gap = pick_gap((seen_cnt / 60) % 4 inside {1, 2});
      end
      if (rx_gap > 0) begin
        rx_gap--;
        rx_rdy = 1'b0;
      end else begin
        rx_rdy = 1'b1;
      end
      out_ready_i <= rx_rdy && !rx_hold;
    end
  end

  // stimulus, then drain and verdict
  initial begin
    int   i;
    int   mode;
    logic signed [31:0] pattern;
    deq_front    = 0;
    deq_back     = 0;
    deq_empty    = 1'b1;
    total_req    = 0;
    accepted_cnt = 0;
    seen_cnt     = 0;
    mismatch_cnt = 0;

    // pops on an empty deque
    add_request(OP_POP_FRONT, 32'sh1234_5678);
    add_request(OP_POP_BACK, -32'sd1);
    // push into empty, then push front with front at slot 0 (shift)
    add_request(OP_PUSH_BACK, 32'sh7fff_ffff);
    add_request(OP_PUSH_FRONT, 32'sh8000_0000);
    // front moves off slot 0, then push front without a shift
    add_request(OP_POP_FRONT, '0);
    add_request(OP_PUSH_FRONT, '0);
    // drain through the back until the last entry leaves
    add_request(OP_POP_BACK, '0);
    add_request(OP_POP_BACK, '0);
    // fill every slot, then both pushes get refused
    for (i = 0; i < DEPTH; i++) begin
      pattern = (i % 2 == 0) ? 32'shaaaa_aaaa : 32'sh5555_5555;
      add_request(OP_PUSH_BACK, pattern ^ i);
    end
    add_request(OP_PUSH_BACK, -32'sd1);
    add_request(OP_PUSH_FRONT, 32'sh7fff_ffff);

    // random phases: fill-heavy, drain-heavy and uniform stretches
    mode = 0;
    for (i = 0; i < 675; i++) begin
      if (i % 30 == 0) begin
        mode = $urandom_range(0, 2);
      end
      add_request(pick_op(mode), pick_value());
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (accepted_cnt != total_req || outcome_q.size() != 0) begin
      @(posedge clk_i);
    end
    // room for a late stray result, longest path is a full shift
    repeat (40) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
